>>> sv/preemptive_priority_scheduler_macros.svh
// assertion macros for the preemptive priority scheduler
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_MACROS_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_MACROS_SVH

// property that must hold at every clock edge out of reset
`define PPS_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// property whose consequent must hold in the cycle after the antecedent
`define PPS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/pps_pkg.sv
// shared constants and the token type passed along the scheduler cell chain
package pps_pkg;

    localparam int MAX_PROCS = 16;
    localparam int IDX_W     = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CNT_W     = $clog2(MAX_PROCS + 1);
    localparam int TIME_W    = 16;
    localparam int PRI_W     = 8;
    localparam int SLOT_W    = 4;
    localparam int PCOUNT_W  = 5;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    typedef struct packed {
        logic              valid;
        logic [IDX_W-1:0]  idx;
        logic [PRI_W-1:0]  pri;
        logic [TIME_W-1:0] arrival;
        logic [TIME_W-1:0] burst;
        logic              last;
        logic [CNT_W-1:0]  undone;
    } token_t;

endpackage

>>> sv/preemptive_priority_scheduler.sv
// top level: command decode, tick sequencing and result registers over the cell chain
//
//  channel    | handshake                 | fields
//  -----------+---------------------------+------------------------------------------------
//  command in | start, busy               | command, slot, arrival_time, burst_time,
//             |                           | priority_req
//  config     | process_count_we          | process_count
//  result out | result_valid (one cycle)  | idle, running_slot, finished, turnaround,
//             |                           | waiting, all_done, tick_time
//
// a load beat gives no result; busy stays low
// a tick beat raises busy; in ST_SCAN the best candidate ripples one cell per cycle
// down the chain of MAX_PROCS cells, then ST_APPLY writes back and registers the result
// result_valid rises the cycle after write-back, when busy is already low again
// reset clears the clock, the done flags and the slot count; slot contents stay unknown
// the receiver cannot stall the result, so nothing upstream waits on it
module preemptive_priority_scheduler (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            command,
    input  logic [pps_pkg::SLOT_W-1:0]      slot,
    input  logic [pps_pkg::TIME_W-1:0]      arrival_time,
    input  logic [pps_pkg::TIME_W-1:0]      burst_time,
    input  logic [pps_pkg::PRI_W-1:0]       priority_req,
    input  logic                            process_count_we,
    input  logic [pps_pkg::PCOUNT_W-1:0]    process_count,
    output logic                            result_valid,
    output logic                            idle,
    output logic [pps_pkg::SLOT_W-1:0]      running_slot,
    output logic                            finished,
    output logic [pps_pkg::TIME_W-1:0]      turnaround,
    output logic [pps_pkg::TIME_W-1:0]      waiting,
    output logic                            all_done,
    output logic [pps_pkg::TIME_W-1:0]      tick_time
);

    `include "preemptive_priority_scheduler_macros.svh"

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_APPLY
    } state_t;

    state_t                        state_reg;
    logic [pps_pkg::IDX_W-1:0]     scan_cnt_reg;
    logic [pps_pkg::TIME_W-1:0]    clock_now_reg;
    logic [pps_pkg::PCOUNT_W-1:0]  process_count_reg;
    logic                          result_valid_reg;
    logic                          idle_reg;
    logic [pps_pkg::SLOT_W-1:0]    running_slot_reg;
    logic                          finished_reg;
    logic [pps_pkg::TIME_W-1:0]    turnaround_reg;
    logic [pps_pkg::TIME_W-1:0]    waiting_reg;
    logic                          all_done_reg;
    logic [pps_pkg::TIME_W-1:0]    tick_time_reg;

    logic                          accept;
    logic                          load_now;
    logic                          apply_now;
    logic [pps_pkg::CNT_W-1:0]     use_count;
    logic [pps_pkg::TIME_W-1:0]    clock_after;
    logic                          fin;
    logic [pps_pkg::TIME_W-1:0]    tat;
    pps_pkg::token_t               best;
    pps_pkg::token_t               chain_in [pps_pkg::MAX_PROCS];
    pps_pkg::token_t               chain_out [pps_pkg::MAX_PROCS];
    logic [pps_pkg::MAX_PROCS-1:0] load_sel;
    logic [pps_pkg::MAX_PROCS-1:0] apply_sel;

    assign busy      = (state_reg != ST_IDLE);
    assign accept    = start && !busy;
    assign load_now  = accept && (command == pps_pkg::CMD_LOAD);
    assign apply_now = (state_reg == ST_APPLY);

    assign use_count = (32'(process_count_reg) > pps_pkg::MAX_PROCS) ?
                       pps_pkg::CNT_W'(pps_pkg::MAX_PROCS) :
                       pps_pkg::CNT_W'(process_count_reg);

    assign best        = chain_out[pps_pkg::MAX_PROCS-1];
    assign clock_after = clock_now_reg + pps_pkg::TIME_W'(1);
    assign fin         = best.valid && best.last;
    assign tat         = clock_after - best.arrival;

    genvar gi;
    generate
        for (gi = 0; gi < pps_pkg::MAX_PROCS; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_head
                assign chain_in[gi] = '0;
            end
            else
            begin : g_link
                assign chain_in[gi] = chain_out[gi-1];
            end

            assign load_sel[gi]  = load_now && (32'(slot) == gi);
            assign apply_sel[gi] = apply_now && best.valid &&
                                   (best.idx == pps_pkg::IDX_W'(gi));

            pps_cell u_cell (
                .clk          (clk),
                .rst_n        (rst_n),
                .cell_idx     (pps_pkg::IDX_W'(gi)),
                .use_count    (use_count),
                .clock_now    (clock_now_reg),
                .load_sel     (load_sel[gi]),
                .load_arrival (arrival_time),
                .load_burst   (burst_time),
                .load_pri     (priority_req),
                .apply_sel    (apply_sel[gi]),
                .tok_in       (chain_in[gi]),
                .tok_out      (chain_out[gi])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            scan_cnt_reg      <= '0;
            clock_now_reg     <= '0;
            process_count_reg <= '0;
            result_valid_reg  <= 1'b0;
            idle_reg          <= 1'b0;
            running_slot_reg  <= '0;
            finished_reg      <= 1'b0;
            turnaround_reg    <= '0;
            waiting_reg       <= '0;
            all_done_reg      <= 1'b0;
            tick_time_reg     <= '0;
        end
        else
        begin
            result_valid_reg <= 1'b0;
            if (process_count_we)
            begin
                process_count_reg <= process_count;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept && (command == pps_pkg::CMD_TICK))
                    begin
                        scan_cnt_reg <= '0;
                        state_reg    <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    // the last cell holds the winner once the chain has fully settled
                    if (scan_cnt_reg == pps_pkg::IDX_W'(pps_pkg::MAX_PROCS - 1))
                    begin
                        state_reg <= ST_APPLY;
                    end
                    scan_cnt_reg <= scan_cnt_reg + pps_pkg::IDX_W'(1);
                end
                ST_APPLY:
                begin
                    clock_now_reg    <= clock_after;
                    result_valid_reg <= 1'b1;
                    idle_reg         <= !best.valid;
                    running_slot_reg <= best.valid ? pps_pkg::SLOT_W'(best.idx) : '0;
                    finished_reg     <= fin;
                    turnaround_reg   <= fin ? tat : '0;
                    waiting_reg      <= fin ? (tat - best.burst) : '0;
                    all_done_reg     <= ((best.undone - pps_pkg::CNT_W'(fin)) == '0);
                    tick_time_reg    <= clock_after;
                    state_reg        <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign result_valid = result_valid_reg;
    assign idle         = idle_reg;
    assign running_slot = running_slot_reg;
    assign finished     = finished_reg;
    assign turnaround   = turnaround_reg;
    assign waiting      = waiting_reg;
    assign all_done     = all_done_reg;
    assign tick_time    = tick_time_reg;

    `PPS_ASSERT_NEXT(a_apply_gives_result, state_reg == ST_APPLY, result_valid_reg, "write-back without result beat")
    `PPS_ASSERT_NEXT(a_tick_goes_busy, accept && (command == pps_pkg::CMD_TICK), busy, "tick accepted but block not busy")
    `PPS_ASSERT_ALWAYS(a_finish_not_idle, !(result_valid_reg && finished_reg && idle_reg), "finished on an idle tick")
    `PPS_ASSERT_ALWAYS(a_tick_time_tracks, !result_valid_reg || (tick_time_reg == clock_now_reg), "tick_time differs from clock")

endmodule

>>> sv/pps_cell.sv
// one process slot of the scheduler chain: slot state plus best-candidate merge
module pps_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [pps_pkg::IDX_W-1:0]     cell_idx,
    input  logic [pps_pkg::CNT_W-1:0]     use_count,
    input  logic [pps_pkg::TIME_W-1:0]    clock_now,
    input  logic                          load_sel,
    input  logic [pps_pkg::TIME_W-1:0]    load_arrival,
    input  logic [pps_pkg::TIME_W-1:0]    load_burst,
    input  logic [pps_pkg::PRI_W-1:0]     load_pri,
    input  logic                          apply_sel,
    input  pps_pkg::token_t               tok_in,
    output pps_pkg::token_t               tok_out
);

    logic [pps_pkg::TIME_W-1:0] arrival_reg;
    logic [pps_pkg::TIME_W-1:0] burst_reg;
    logic [pps_pkg::TIME_W-1:0] remaining_reg;
    logic [pps_pkg::PRI_W-1:0]  pri_reg;
    logic                       done_reg;
    pps_pkg::token_t            tok_reg;
    pps_pkg::token_t            tok_next;

    logic in_use;
    logic own_ready;
    logic own_better;
    logic own_last;

    assign in_use    = (pps_pkg::CNT_W'(cell_idx) < use_count);
    assign own_ready = in_use && !done_reg && (arrival_reg <= clock_now);
    assign own_last  = (remaining_reg <= pps_pkg::TIME_W'(1));

    // incoming token comes from lower slots, so it keeps full ties
    assign own_better = own_ready &&
        (!tok_in.valid || (pri_reg < tok_in.pri) ||
         ((pri_reg == tok_in.pri) && (arrival_reg < tok_in.arrival)));

    always_comb
    begin
        tok_next = tok_in;
        if (own_better)
        begin
            tok_next.valid   = 1'b1;
            tok_next.idx     = cell_idx;
            tok_next.pri     = pri_reg;
            tok_next.arrival = arrival_reg;
            tok_next.burst   = burst_reg;
            tok_next.last    = own_last;
        end
        tok_next.undone = tok_in.undone + pps_pkg::CNT_W'(in_use && !done_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
            tok_reg  <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
            if (load_sel)
            begin
                done_reg <= 1'b0;
            end
            else if (apply_sel && own_last)
            begin
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_sel)
        begin
            arrival_reg   <= load_arrival;
            burst_reg     <= load_burst;
            remaining_reg <= load_burst;
            pri_reg       <= load_pri;
        end
        else if (apply_sel)
        begin
            remaining_reg <= own_last ? '0 : remaining_reg - pps_pkg::TIME_W'(1);
        end
    end

    assign tok_out = tok_reg;

endmodule

>>> bench/schedule_checker.sv
// watches the scheduler command and result beats, predicts each tick result and compares
`timescale 1ns / 100ps

module schedule_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic                            busy,
    input  logic                            command,
    input  logic [pps_pkg::SLOT_W-1:0]      slot,
    input  logic [pps_pkg::TIME_W-1:0]      arrival_time,
    input  logic [pps_pkg::TIME_W-1:0]      burst_time,
    input  logic [pps_pkg::PRI_W-1:0]       priority_req,
    input  logic                            process_count_we,
    input  logic [pps_pkg::PCOUNT_W-1:0]    process_count,
    input  logic                            result_valid,
    input  logic                            idle,
    input  logic [pps_pkg::SLOT_W-1:0]      running_slot,
    input  logic                            finished,
    input  logic [pps_pkg::TIME_W-1:0]      turnaround,
    input  logic [pps_pkg::TIME_W-1:0]      waiting,
    input  logic                            all_done,
    input  logic [pps_pkg::TIME_W-1:0]      tick_time,
    output int                              fail_count,
    output int                              pending_results
);
    import pps_pkg::*;

    typedef struct packed {
        logic              idle;
        logic [SLOT_W-1:0] served;
        logic              finished;
        logic [TIME_W-1:0] turnaround;
        logic [TIME_W-1:0] waiting;
        logic              all_done;
        logic [TIME_W-1:0] tick_time;
    } tick_result_t;

    // scheduler state as the block should hold it
    logic [TIME_W-1:0]   arr_q   [MAX_PROCS];
    logic [TIME_W-1:0]   burst_q [MAX_PROCS];
    logic [TIME_W-1:0]   left_q  [MAX_PROCS];
    logic [PRI_W-1:0]    pri_q   [MAX_PROCS];
    logic                done_q  [MAX_PROCS];
    logic [TIME_W-1:0]   now_q;
    logic [PCOUNT_W-1:0] count_q;

    tick_result_t tick_results_due [$];
    int           mismatches = 0;

    task automatic report_mismatch(input string what);
        $display("%0t: tick result mismatch: %s", $time, what);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [TIME_W-1:0] got,
                               input logic [TIME_W-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        tick_result_t want;
        int in_use;
        int pick;
        int i;
        int idx;
        logic [TIME_W-1:0] span;
        if (!rst_n)
        begin
            for (i = 0; i < MAX_PROCS; i++)
                done_q[i] = 1'b0;
            now_q = '0;
            count_q = '0;
            tick_results_due.delete();
            pending_results <= 0;
        end
        else
        begin
            if (process_count_we)
                count_q = process_count;

            if (result_valid)
            begin
                if (tick_results_due.size() == 0)
                    report_mismatch("result beat with no tick outstanding");
                else
                begin
                    want = tick_results_due.pop_front();
                    check_field("idle", TIME_W'(idle), TIME_W'(want.idle));
                    check_field("running_slot", TIME_W'(running_slot), TIME_W'(want.served));
                    check_field("finished", TIME_W'(finished), TIME_W'(want.finished));
                    check_field("turnaround", turnaround, want.turnaround);
                    check_field("waiting", waiting, want.waiting);
                    check_field("all_done", TIME_W'(all_done), TIME_W'(want.all_done));
                    check_field("tick_time", tick_time, want.tick_time);
                end
            end

            if (start && !busy)
            begin
                if (command == CMD_LOAD)
                begin
                    idx = int'(slot);
                    if (idx < MAX_PROCS)
                    begin
                        arr_q[idx]   = arrival_time;
                        burst_q[idx] = burst_time;
                        left_q[idx]  = burst_time;
                        pri_q[idx]   = priority_req;
                        done_q[idx]  = 1'b0;
                    end
                end
                else
                begin
                    want = '0;
                    in_use = (int'(count_q) > MAX_PROCS) ? MAX_PROCS : int'(count_q);
                    // lowest priority number wins, then earliest arrival, then lowest slot
                    pick = -1;
                    for (i = 0; i < in_use; i++)
                    begin
                        if (!done_q[i] && arr_q[i] <= now_q)
                        begin
                            if (pick < 0 || pri_q[i] < pri_q[pick] ||
                                (pri_q[i] == pri_q[pick] && arr_q[i] < arr_q[pick]))
                                pick = i;
                        end
                    end
                    now_q = now_q + 1'b1;
                    want.idle = (pick < 0);
                    if (pick >= 0)
                    begin
                        want.served = SLOT_W'(pick);
                        // a zero burst finishes on its first served tick like a burst of one
                        if (left_q[pick] <= 1)
                        begin
                            left_q[pick] = '0;
                            done_q[pick] = 1'b1;
                            span = now_q - arr_q[pick];
                            want.finished = 1'b1;
                            want.turnaround = span;
                            want.waiting = span - burst_q[pick];
                        end
                        else
                            left_q[pick] = left_q[pick] - 1'b1;
                    end
                    want.all_done = 1'b1;
                    for (i = 0; i < in_use; i++)
                        if (!done_q[i])
                            want.all_done = 1'b0;
                    want.tick_time = now_q;
                    tick_results_due.push_back(want);
                end
            end
            pending_results <= tick_results_due.size();
        end
        fail_count <= mismatches;
    end

endmodule

>>> bench/tb.sv
// testbench top: drives scheduler commands and slot-count writes, gives the verdict
`timescale 1ns / 100ps

module tb;
    import pps_pkg::*;

    localparam int IDLE_LIMIT    = 4000;
    localparam int SETTLE_CYCLES = MAX_PROCS + 6;
    localparam int PHASE_ITEMS   = 640;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic                command;
    logic [SLOT_W-1:0]   slot;
    logic [TIME_W-1:0]   arrival_time;
    logic [TIME_W-1:0]   burst_time;
    logic [PRI_W-1:0]    priority_req;
    logic                process_count_we;
    logic [PCOUNT_W-1:0] process_count;
    logic                result_valid;
    logic                idle;
    logic [SLOT_W-1:0]   running_slot;
    logic                finished;
    logic [TIME_W-1:0]   turnaround;
    logic [TIME_W-1:0]   waiting;
    logic                all_done;
    logic [TIME_W-1:0]   tick_time;
    int                  fail_count;
    int                  pending_results;

    // ticks issued so far, so loads can arrive near the scheduler clock
    logic [TIME_W-1:0]   sched_now;
    int                  items_sent;
    int                  idle_pct;

    preemptive_priority_scheduler u_top (.*);

    schedule_checker u_check (.*);

    initial clk = 1'b0;
    always #5 clk = ~clk;

    task automatic send_beat(input logic cmd, input logic [SLOT_W-1:0] s,
                             input logic [TIME_W-1:0] arr, input logic [TIME_W-1:0] bur,
                             input logic [PRI_W-1:0] pri);
        logic taken;
        while ($urandom_range(99, 0) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        command <= cmd;
        slot <= s;
        arrival_time <= arr;
        burst_time <= bur;
        priority_req <= pri;
        // busy only moves on rising edges, so the falling edge shows what the next edge sees
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = !busy;
            @(posedge clk);
        end
        if (cmd == CMD_TICK)
            sched_now = sched_now + 1'b1;
        items_sent++;
    endtask

    task automatic load_slot(input logic [SLOT_W-1:0] s, input logic [TIME_W-1:0] arr,
                             input logic [TIME_W-1:0] bur, input logic [PRI_W-1:0] pri);
        send_beat(CMD_LOAD, s, arr, bur, pri);
    endtask

    // payload fields are don't-care on a tick, so they carry noise
    task automatic tick();
        send_beat(CMD_TICK, SLOT_W'($urandom), TIME_W'($urandom), TIME_W'($urandom),
                  PRI_W'($urandom));
    endtask

    task automatic write_count(input logic [PCOUNT_W-1:0] value);
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending_results != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        process_count_we <= 1'b1;
        process_count <= value;
        @(posedge clk);
        process_count_we <= 1'b0;
    endtask

    task automatic load_random(input int s);
        logic [TIME_W-1:0] arr;
        logic [TIME_W-1:0] bur;
        logic [PRI_W-1:0]  pri;
        if ($urandom_range(9, 0) == 0)
        begin
            // noise: anything the fields allow
            arr = TIME_W'($urandom);
            bur = TIME_W'($urandom);
            pri = PRI_W'($urandom);
        end
        else
        begin
            arr = sched_now + TIME_W'($urandom_range(12, 0));
            bur = ($urandom_range(14, 0) == 0) ? '0 : TIME_W'($urandom_range(6, 1));
            pri = $urandom_range(1, 0) ? PRI_W'($urandom_range(3, 0))
                                       : PRI_W'($urandom_range(255, 0));
        end
        load_slot(SLOT_W'(s), arr, bur, pri);
    endtask

    initial
    begin : stimulus
        int k;
        int phase;
        int phase_end;
        int in_use;
        int tick_count;
        int phase_pct [3];
        logic [PCOUNT_W-1:0] count;
        phase_pct[0] = 0;
        phase_pct[1] = 74;
        phase_pct[2] = 35;
        rst_n <= 1'b0;
        start <= 1'b0;
        command <= CMD_LOAD;
        slot <= '0;
        arrival_time <= '0;
        burst_time <= '0;
        priority_req <= '0;
        process_count_we <= 1'b0;
        process_count <= '0;
        sched_now = '0;
        items_sent = 0;
        idle_pct = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // no slots in use: idle ticks with all_done set
        tick();
        tick();
        // every slot gets written before any count can reach it
        load_slot(4'd0, 16'h0000, 16'h0000, 8'd255);
        load_slot(4'd1, 16'h0000, 16'h0001, 8'd0);
        load_slot(4'd2, 16'hFFFF, 16'hFFFF, 8'd0);
        load_slot(4'd3, 16'h0001, 16'h0002, 8'd0);
        load_slot(4'd4, 16'h0001, 16'h0002, 8'd0);
        for (k = 5; k < MAX_PROCS; k++)
            load_slot(SLOT_W'(k), (k % 2) ? 16'h5555 : 16'hAAAA, 16'h0003, PRI_W'(k * 17));
        write_count(5'd5);
        repeat (7) tick();
        // counts above the slot total saturate
        write_count(5'd31);
        tick();
        write_count(5'd16);
        load_slot(4'd1, sched_now, 16'h0002, 8'd0);
        tick();
        tick();

        for (phase = 0; phase < 3; phase++)
        begin
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end)
            begin
                idle_pct = ($urandom_range(4, 0) == 0) ? 0 : phase_pct[phase];
                k = $urandom_range(19, 0);
                if (k == 0)
                    count = '0;
                else if (k == 1)
                    count = PCOUNT_W'($urandom_range(31, 17));
                else
                    count = PCOUNT_W'($urandom_range(16, 1));
                write_count(count);
                in_use = (int'(count) > MAX_PROCS) ? MAX_PROCS : int'(count);
                for (k = 0; k < in_use; k++)
                    load_random(k);
                tick_count = $urandom_range(40, 8);
                for (k = 0; k < tick_count; k++)
                begin
                    // late arrivals and reloads preempt the running process
                    if (in_use > 0 && $urandom_range(7, 0) == 0)
                        load_random($urandom_range(in_use - 1, 0));
                    else
                        tick();
                end
            end
        end

        start <= 1'b0;
        do
            @(posedge clk);
        while (pending_results != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("[preemptive_priority_scheduler] OK");
        else
            $display("[preemptive_priority_scheduler] ERROR");
        $finish;
    end

    initial
    begin : watchdog
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((start && !busy) || result_valid)
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("[preemptive_priority_scheduler] ERROR");
        $finish;
    end

endmodule

>>> sim.f
+incdir+sv
sv/pps_pkg.sv
sv/pps_cell.sv
sv/preemptive_priority_scheduler.sv
bench/schedule_checker.sv
bench/tb.sv
